/* hdl/prt_pkg.sv */
// shared types and constants of the pending request table
`default_nettype none
package prt_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int ADDR_W = 48;
	localparam int WORD_W = 32;
	localparam int USED_W = 5;
	localparam logic [WORD_W-1:0] TIMEOUT_RESET = 32'd30000;

	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_ADD = 2'd1;
	localparam logic [1:0] CMD_TAKE = 2'd2;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [ADDR_W-1:0] node_address;
		logic [WORD_W-1:0] session_in;
	} req_t;

	typedef struct packed {
		logic              ok;
		logic [WORD_W-1:0] session_out;
		logic [USED_W-1:0] entries_used;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic [WORD_W-1:0] session;
		logic [WORD_W-1:0] stamp;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PR_RD,
		ST_PR_CHK,
		ST_PR_MOV,
		ST_FINISH,
		ST_TK_MOV
	} state_t;

endpackage
`default_nettype wire

/* hdl/prt_ram.sv */
// generic simple dual port ram with registered read
`default_nettype none
module prt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

/* hdl/pending_request_table_with_timeout.sv */
// top level: pending request table with timeout pruning, add and take
// A tick or the unused command is handled in idle, and its result strobe (done) comes in
// the next cycle. An add or a take walks the table once through the single read port of the
// entry ram: each expired entry costs a read of the last entry, a write and a re-read, and a
// take whose hit is not the last entry then moves the last entry into the freed slot; the
// strobe is registered after the end of work. busy is high for an add or a take from the
// accepting edge until the strobe cycle; a tick never raises it. done is valid for exactly
// one cycle and the receiver cannot stall it; rsp holds until the next result. Configuration
// writes are always taken (cfg_ready is high) and belong in idle periods.
`default_nettype none
module pending_request_table_with_timeout (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire prt_pkg::req_t                 req,
	output logic                               done,
	output prt_pkg::rsp_t                      rsp,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [prt_pkg::WORD_W-1:0]    cfg_data
);

	localparam int EW = $bits(prt_pkg::entry_t);

	prt_pkg::state_t state_q, state_d;
	prt_pkg::req_t req_q;
	prt_pkg::rsp_t rsp_q, rsp_d;
	logic done_q, done_d;
	logic [prt_pkg::CNT_W-1:0] fill_q, fill_d;
	logic [prt_pkg::CNT_W-1:0] idx_q, idx_d;
	logic [prt_pkg::WORD_W-1:0] time_q, time_d;
	logic [prt_pkg::WORD_W-1:0] timeout_q;
	logic found_q, found_d;
	logic [prt_pkg::IDX_W-1:0] mi_q, mi_d;
	logic [prt_pkg::WORD_W-1:0] msess_q, msess_d;

	logic ram_we;
	logic [prt_pkg::IDX_W-1:0] ram_waddr, ram_raddr;
	prt_pkg::entry_t ram_wdata, rd;
	logic [EW-1:0] ram_rdata;
	logic [prt_pkg::WORD_W-1:0] age;
	logic expired;

	prt_ram #(
		.WIDTH(EW),
		.DEPTH(prt_pkg::DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd = prt_pkg::entry_t'(ram_rdata);
	// wrapping age, then the one compare against the timeout
	assign age = time_q - rd.stamp;
	assign expired = (age >= timeout_q);

	always_comb begin
		state_d = state_q;
		fill_d = fill_q;
		idx_d = idx_q;
		time_d = time_q;
		found_d = found_q;
		mi_d = mi_q;
		msess_d = msess_q;
		done_d = 1'b0;
		rsp_d = rsp_q;
		ram_we = 1'b0;
		ram_waddr = idx_q[prt_pkg::IDX_W-1:0];
		ram_wdata = rd;
		ram_raddr = idx_q[prt_pkg::IDX_W-1:0];
		case (state_q)
			prt_pkg::ST_IDLE: begin
				if (start) begin
					case (req.cmd)
						prt_pkg::CMD_ADD, prt_pkg::CMD_TAKE: begin
							idx_d = '0;
							found_d = 1'b0;
							state_d = prt_pkg::ST_PR_RD;
						end
						default: begin
							if (req.cmd == prt_pkg::CMD_TICK) begin
								time_d = time_q + 32'd1;
							end
							done_d = 1'b1;
							rsp_d.ok = 1'b0;
							rsp_d.session_out = '0;
							rsp_d.entries_used = prt_pkg::USED_W'(fill_q);
						end
					endcase
				end
			end
			prt_pkg::ST_PR_RD: begin
				if (idx_q < fill_q) begin
					state_d = prt_pkg::ST_PR_CHK;
				end else begin
					state_d = prt_pkg::ST_FINISH;
				end
			end
			prt_pkg::ST_PR_CHK: begin
				if (expired) begin
					fill_d = fill_q - prt_pkg::CNT_W'(1);
					ram_raddr = fill_d[prt_pkg::IDX_W-1:0];
					if (idx_q < fill_d) begin
						state_d = prt_pkg::ST_PR_MOV;
					end else begin
						state_d = prt_pkg::ST_FINISH;
					end
				end else begin
					// a surviving entry keeps its slot, so the first hit is final
					if (!found_q && rd.address == req_q.node_address) begin
						found_d = 1'b1;
						mi_d = idx_q[prt_pkg::IDX_W-1:0];
						msess_d = rd.session;
					end
					idx_d = idx_q + prt_pkg::CNT_W'(1);
					ram_raddr = idx_d[prt_pkg::IDX_W-1:0];
					if (idx_d >= fill_q) begin
						state_d = prt_pkg::ST_FINISH;
					end
				end
			end
			prt_pkg::ST_PR_MOV: begin
				// last word lands in the expired slot, then gets checked again
				ram_we = 1'b1;
				state_d = prt_pkg::ST_PR_RD;
			end
			prt_pkg::ST_FINISH: begin
				rsp_d.session_out = '0;
				rsp_d.ok = 1'b0;
				if (req_q.cmd == prt_pkg::CMD_ADD) begin
					ram_wdata.address = req_q.node_address;
					ram_wdata.session = req_q.session_in;
					ram_wdata.stamp = time_q;
					if (found_q) begin
						ram_we = 1'b1;
						ram_waddr = mi_q;
						rsp_d.ok = 1'b1;
					end else if (fill_q < prt_pkg::CNT_W'(prt_pkg::DEPTH)) begin
						ram_we = 1'b1;
						ram_waddr = fill_q[prt_pkg::IDX_W-1:0];
						fill_d = fill_q + prt_pkg::CNT_W'(1);
						rsp_d.ok = 1'b1;
					end
					done_d = 1'b1;
					state_d = prt_pkg::ST_IDLE;
				end else begin
					if (found_q) begin
						rsp_d.ok = 1'b1;
						rsp_d.session_out = msess_q;
						fill_d = fill_q - prt_pkg::CNT_W'(1);
						ram_raddr = fill_d[prt_pkg::IDX_W-1:0];
						if (prt_pkg::CNT_W'(mi_q) < fill_d) begin
							state_d = prt_pkg::ST_TK_MOV;
						end else begin
							done_d = 1'b1;
							state_d = prt_pkg::ST_IDLE;
						end
					end else begin
						done_d = 1'b1;
						state_d = prt_pkg::ST_IDLE;
					end
				end
				rsp_d.entries_used = prt_pkg::USED_W'(fill_d);
			end
			prt_pkg::ST_TK_MOV: begin
				ram_we = 1'b1;
				ram_waddr = mi_q;
				done_d = 1'b1;
				state_d = prt_pkg::ST_IDLE;
			end
			default: begin
				state_d = prt_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prt_pkg::ST_IDLE;
			fill_q <= '0;
			time_q <= '0;
			idx_q <= '0;
			found_q <= 1'b0;
			done_q <= 1'b0;
			timeout_q <= prt_pkg::TIMEOUT_RESET;
		end else begin
			state_q <= state_d;
			fill_q <= fill_d;
			time_q <= time_d;
			idx_q <= idx_d;
			found_q <= found_d;
			done_q <= done_d;
			if (cfg_valid && cfg_ready) begin
				timeout_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == prt_pkg::ST_IDLE && start) begin
			req_q <= req;
		end
		mi_q <= mi_d;
		msess_q <= msess_d;
		rsp_q <= rsp_d;
	end

	assign busy = (state_q != prt_pkg::ST_IDLE);
	assign done = done_q;
	assign rsp = rsp_q;
	assign cfg_ready = 1'b1;

endmodule
`default_nettype wire
